[rtl/iee_pkg.sv]
// package for the infix expression evaluator
// holds widths, operator codes, status codes and the precedence function; no dependencies
package iee_pkg;

   localparam int StackDepth = 16;
   localparam int ValueWidth = 32;
   localparam int PtrWidth   = $clog2(StackDepth);
   localparam int CntWidth   = $clog2(StackDepth + 1);

   typedef logic [ValueWidth-1:0] value_type;
   typedef logic [CntWidth-1:0]   count_type;
   typedef logic [PtrWidth-1:0]   ptr_type;

   typedef enum logic [2:0] {
      OP_OPEN = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_NEG  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      PC_START = 2'd0,
      PC_OPEN  = 2'd1,
      PC_OPER  = 2'd2,
      PC_OTHER = 2'd3
   } class_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_OVERFLOW  = 3'd1,
      ST_MALFORMED = 3'd2,
      ST_DIVZERO   = 3'd3,
      ST_PARENS    = 3'd4
   } status_type;

   // request and reply between sequencer and alu
   typedef struct packed {
      logic   start;
      op_type op;
   } alu_req_type;

   typedef struct packed {
      logic   done;
      logic   div_zero;
   } alu_rsp_type;

   // operator precedence
   function automatic logic [1:0] prec_of(input op_type op);
      logic [1:0] p;
      unique case (op)
         OP_ADD, OP_SUB: p = 2'd1;
         OP_MUL, OP_DIV: p = 2'd2;
         OP_NEG:         p = 2'd3;
         default:        p = 2'd0;
      endcase
      return p;
   endfunction

endpackage

[rtl/iee_alu.sv]
// shared arithmetic unit: add, subtract, negate, multiply, restoring divide
// depends on iee_pkg; division runs one quotient bit a cycle
module iee_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  iee_pkg::alu_req_type req,
   input  iee_pkg::value_type   opa,
   input  iee_pkg::value_type   opb,
   output iee_pkg::alu_rsp_type rsp,
   output iee_pkg::value_type   result
);

   localparam int W  = iee_pkg::ValueWidth;
   localparam int BW = $clog2(W + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               dz_ff, dz_in;
   logic [BW-1:0]      bit_ff, bit_in;
   logic [W-1:0]       rem_ff, rem_in;
   logic [W-1:0]       quo_ff, quo_in;
   logic [W-1:0]       dvs_ff, dvs_in;
   logic               neg_ff, neg_in;
   iee_pkg::value_type res_ff, res_in;
   logic [W:0]         trial;
   logic [W-1:0]       ma, mb;
   logic [W-1:0]       shifted;

   assign ma = opa[W-1] ? (W'(0) - opa) : opa;
   assign mb = opb[W-1] ? (W'(0) - opb) : opb;
   assign shifted = {rem_ff[W-2:0], quo_ff[W-1]};
   assign trial = {1'b0, shifted} - {1'b0, dvs_ff};

   // sequencing of one operation
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      dz_in   = 1'b0;
      bit_in  = bit_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      if (busy_ff) begin
         rem_in = trial[W] ? shifted : trial[W-1:0];
         quo_in = {quo_ff[W-2:0], ~trial[W]};
         bit_in = bit_ff - BW'(1);
         if (bit_ff == BW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? (W'(0) - {quo_ff[W-2:0], ~trial[W]})
                             : {quo_ff[W-2:0], ~trial[W]};
         end
      end else if (req.start) begin
         unique case (req.op)
            iee_pkg::OP_ADD: begin res_in = opa + opb; done_in = 1'b1; end
            iee_pkg::OP_SUB: begin res_in = opa - opb; done_in = 1'b1; end
            iee_pkg::OP_MUL: begin res_in = W'(opa * opb); done_in = 1'b1; end
            iee_pkg::OP_NEG: begin res_in = W'(0) - opb; done_in = 1'b1; end
            iee_pkg::OP_DIV: begin
               if (opb == '0) begin
                  dz_in   = 1'b1;
                  done_in = 1'b1;
               end else begin
                  busy_in = 1'b1;
                  bit_in  = BW'(W);
                  rem_in  = '0;
                  quo_in  = ma;
                  dvs_in  = mb;
                  neg_in  = opa[W-1] ^ opb[W-1];
               end
            end
            default: done_in = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         dz_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         dz_ff   <= dz_in;
      end
      bit_ff <= bit_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.div_zero = dz_ff;
   assign result       = res_ff;

endmodule

[rtl/infix_expression_evaluator_core.sv]
// infix expression evaluator top level: character sequencer, two stacks, shared alu
// depends on iee_pkg and iee_alu
// sequence: a digit or space is taken in idle; '(', unary minus or another character also in decode,
// ')' or a binary operator also in pop and fetch; each operator applied passes alu and wait, a divide
// waiting on the bit-serial divider in iee_alu; the last beat also drains both stacks
// reset: synchronous, clears counts, accumulator, class and error; stack entries are not cleared
module infix_expression_evaluator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_value,
   output logic [2:0]  rsp_status
);

   localparam int W = iee_pkg::ValueWidth;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_DECODE = 8'b0000_0010,
      S_POP    = 8'b0000_0100,
      S_FETCH  = 8'b0000_1000,
      S_ALU    = 8'b0001_0000,
      S_WAIT   = 8'b0010_0000,
      S_FINISH = 8'b0100_0000,
      S_OUT    = 8'b1000_0000
   } state_type;

   typedef enum logic [1:0] {
      M_BINARY = 2'd0,
      M_CLOSE  = 2'd1,
      M_DRAIN  = 2'd2
   } mode_type;

   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic [7:0]           char_ff, char_in;
   logic                 last_ff, last_in;
   iee_pkg::op_type      pend_ff, pend_in;
   iee_pkg::op_type      top_ff;
   iee_pkg::count_type   ocnt_ff, ocnt_in;
   iee_pkg::count_type   vcnt_ff, vcnt_in;
   iee_pkg::value_type   acc_ff, acc_in;
   logic                 innum_ff, innum_in;
   iee_pkg::class_type   prev_ff, prev_in;
   iee_pkg::status_type  err_ff, err_in;
   logic                 rv_ff, rv_in;
   iee_pkg::value_type   rval_ff;
   iee_pkg::status_type  rst_ff, rst_in;
   iee_pkg::value_type   opa_ff;
   iee_pkg::value_type   opb_ff;

   // stack memories
   iee_pkg::op_type      ostk [iee_pkg::StackDepth];
   iee_pkg::value_type   vstk [iee_pkg::StackDepth];
   logic                 owe, vwe;
   iee_pkg::ptr_type     owa, vwa;
   iee_pkg::op_type      owd;
   iee_pkg::value_type   vwd;
   logic                 ore, vre, rre, rok;
   iee_pkg::ptr_type     ora, vra, vrb;

   iee_pkg::alu_req_type areq;
   iee_pkg::alu_rsp_type arsp;
   iee_pkg::value_type   ares;

   logic                 is_digit;
   iee_pkg::value_type   acc_next;
   iee_pkg::op_type      bin_op;
   logic                 full_o, full_v;

   iee_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (areq),
      .opa    (opa_ff),
      .opb    (opb_ff),
      .rsp    (arsp),
      .result (ares)
   );

   assign is_digit = (req_char_code >= 8'h30) && (req_char_code <= 8'h39);
   assign acc_next = (acc_ff << 3) + (acc_ff << 1) + W'(req_char_code - 8'h30);
   assign full_o   = ocnt_ff == iee_pkg::count_type'(iee_pkg::StackDepth);
   assign full_v   = vcnt_ff == iee_pkg::count_type'(iee_pkg::StackDepth);

   always_comb begin
      unique case (char_ff)
         8'h2b:   bin_op = iee_pkg::OP_ADD;
         8'h2d:   bin_op = iee_pkg::OP_SUB;
         8'h2a:   bin_op = iee_pkg::OP_MUL;
         default: bin_op = iee_pkg::OP_DIV;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      pend_in  = pend_ff;
      ocnt_in  = ocnt_ff;
      vcnt_in  = vcnt_ff;
      acc_in   = acc_ff;
      innum_in = innum_ff;
      prev_in  = prev_ff;
      err_in   = err_ff;
      rv_in    = rv_ff;
      rst_in   = rst_ff;
      owe = 1'b0; owa = ocnt_ff[iee_pkg::PtrWidth-1:0]; owd = pend_ff;
      vwe = 1'b0; vwa = vcnt_ff[iee_pkg::PtrWidth-1:0]; vwd = acc_ff;
      ore = 1'b0;
      ora = ocnt_ff[iee_pkg::PtrWidth-1:0] - iee_pkg::ptr_type'(1);
      vre = 1'b0;
      vrb = vcnt_ff[iee_pkg::PtrWidth-1:0] - iee_pkg::ptr_type'(1);
      vra = vcnt_ff[iee_pkg::PtrWidth-1:0] - iee_pkg::ptr_type'(2);
      rre = 1'b0;
      rok = 1'b0;
      areq.start = 1'b0;
      areq.op    = top_ff;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !rv_ff) begin
               char_in = req_char_code;
               last_in = req_is_last;
               state_in = S_DECODE;
               if (err_ff == iee_pkg::ST_OK) begin
                  if (req_char_code == 8'h20) begin
                     state_in = req_is_last ? S_FINISH : S_IDLE;
                  end else if (is_digit) begin
                     acc_in   = acc_next;
                     innum_in = 1'b1;
                     prev_in  = iee_pkg::PC_OTHER;
                     state_in = req_is_last ? S_FINISH : S_IDLE;
                  end else if (innum_ff) begin
                     innum_in = 1'b0;
                     acc_in   = '0;
                     if (full_v) err_in = iee_pkg::ST_OVERFLOW;
                     else begin
                        vwe = 1'b1;
                        vcnt_in = vcnt_ff + 1'b1;
                     end
                  end
               end else begin
                  state_in = req_is_last ? S_FINISH : S_IDLE;
               end
            end
         end
         S_DECODE: begin
            state_in = last_ff ? S_FINISH : S_IDLE;
            if (err_ff == iee_pkg::ST_OK) begin
               if (char_ff == 8'h28) begin
                  prev_in = iee_pkg::PC_OPEN;
                  if (full_o) err_in = iee_pkg::ST_OVERFLOW;
                  else begin
                     owe = 1'b1; owd = iee_pkg::OP_OPEN;
                     ocnt_in = ocnt_ff + 1'b1;
                  end
               end else if (char_ff == 8'h29) begin
                  prev_in  = iee_pkg::PC_OTHER;
                  mode_in  = M_CLOSE;
                  state_in = S_POP;
               end else if (char_ff == 8'h7e ||
                            (char_ff == 8'h2d && prev_ff != iee_pkg::PC_OTHER)) begin
                  prev_in = iee_pkg::PC_OPER;
                  if (full_o) err_in = iee_pkg::ST_OVERFLOW;
                  else begin
                     owe = 1'b1; owd = iee_pkg::OP_NEG;
                     ocnt_in = ocnt_ff + 1'b1;
                  end
               end else if (char_ff == 8'h2b || char_ff == 8'h2d ||
                            char_ff == 8'h2a || char_ff == 8'h2f) begin
                  prev_in  = iee_pkg::PC_OPER;
                  pend_in  = bin_op;
                  mode_in  = M_BINARY;
                  state_in = S_POP;
               end else begin
                  prev_in = iee_pkg::PC_OTHER;
               end
            end
         end
         // look at the operator on top and decide
         S_POP: begin
            if (err_ff != iee_pkg::ST_OK) begin
               state_in = last_ff ? S_FINISH : S_IDLE;
               if (mode_ff == M_DRAIN) state_in = S_OUT;
            end else if (ocnt_ff == '0) begin
               unique case (mode_ff)
                  M_BINARY: begin
                     owe = 1'b1; ocnt_in = ocnt_ff + 1'b1;
                     state_in = last_ff ? S_FINISH : S_IDLE;
                  end
                  M_CLOSE: begin
                     err_in = iee_pkg::ST_PARENS;
                     state_in = last_ff ? S_FINISH : S_IDLE;
                  end
                  default: state_in = S_OUT;
               endcase
            end else begin
               ore      = 1'b1;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            if (top_ff == iee_pkg::OP_OPEN) begin
               unique case (mode_ff)
                  M_BINARY: begin
                     if (full_o) err_in = iee_pkg::ST_OVERFLOW;
                     else begin owe = 1'b1; ocnt_in = ocnt_ff + 1'b1; end
                     state_in = last_ff ? S_FINISH : S_IDLE;
                  end
                  M_CLOSE: begin
                     ocnt_in = ocnt_ff - 1'b1;
                     state_in = last_ff ? S_FINISH : S_IDLE;
                  end
                  default: begin
                     err_in = iee_pkg::ST_PARENS;
                     state_in = S_OUT;
                  end
               endcase
            end else if (mode_ff == M_BINARY &&
                         iee_pkg::prec_of(top_ff) < iee_pkg::prec_of(pend_ff)) begin
               if (full_o) err_in = iee_pkg::ST_OVERFLOW;
               else begin owe = 1'b1; ocnt_in = ocnt_ff + 1'b1; end
               state_in = last_ff ? S_FINISH : S_IDLE;
            end else begin
               ocnt_in = ocnt_ff - 1'b1;
               if (top_ff == iee_pkg::OP_NEG ? (vcnt_ff == '0)
                                             : (vcnt_ff < iee_pkg::count_type'(2))) begin
                  err_in = iee_pkg::ST_MALFORMED;
                  state_in = S_POP;
               end else begin
                  vre      = 1'b1;
                  state_in = S_ALU;
               end
            end
         end
         S_ALU: begin
            areq.start = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (arsp.done) begin
               state_in = S_POP;
               if (arsp.div_zero) err_in = iee_pkg::ST_DIVZERO;
               else begin
                  vwe = 1'b1; vwd = ares;
                  if (top_ff == iee_pkg::OP_NEG) begin
                     vwa = vcnt_ff[iee_pkg::PtrWidth-1:0] - 1'b1;
                  end else begin
                     vwa = vcnt_ff[iee_pkg::PtrWidth-1:0] - 2'd2;
                     vcnt_in = vcnt_ff - 1'b1;
                  end
               end
            end
         end
         // end of expression: push pending number, then drain
         S_FINISH: begin
            mode_in = M_DRAIN;
            state_in = S_POP;
            if (err_ff == iee_pkg::ST_OK && innum_ff) begin
               innum_in = 1'b0;
               if (full_v) err_in = iee_pkg::ST_OVERFLOW;
               else begin vwe = 1'b1; vcnt_in = vcnt_ff + 1'b1; end
            end
         end
         S_OUT: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
               rre   = 1'b1;
               if (err_ff == iee_pkg::ST_OK && vcnt_ff != iee_pkg::count_type'(1)) begin
                  rst_in = iee_pkg::ST_MALFORMED;
               end else begin
                  rst_in = err_ff;
                  rok    = (err_ff == iee_pkg::ST_OK);
               end
               ocnt_in = '0; vcnt_in = '0; acc_in = '0; innum_in = 1'b0;
               prev_in = iee_pkg::PC_START; err_in = iee_pkg::ST_OK;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // stack writes and registered reads
   always_ff @(posedge clock) begin
      if (owe) ostk[owa] <= owd;
      if (vwe) vstk[vwa] <= vwd;
      if (ore) top_ff <= ostk[ora];
      if (vre) begin
         opb_ff <= vstk[vrb];
         opa_ff <= vstk[vra];
      end
      if (rre) rval_ff <= rok ? vstk[0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ocnt_ff  <= '0;
         vcnt_ff  <= '0;
         acc_ff   <= '0;
         innum_ff <= 1'b0;
         prev_ff  <= iee_pkg::PC_START;
         err_ff   <= iee_pkg::ST_OK;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ocnt_ff  <= ocnt_in;
         vcnt_ff  <= vcnt_in;
         acc_ff   <= acc_in;
         innum_ff <= innum_in;
         prev_ff  <= prev_in;
         err_ff   <= err_in;
         rv_ff    <= rv_in;
      end
      mode_ff <= mode_in;
      char_ff <= char_in;
      last_ff <= last_in;
      pend_ff <= pend_in;
      rst_ff  <= rst_in;
   end

   assign req_stall  = (state_ff != S_IDLE) || rv_ff;
   assign rsp_valid  = rv_ff;
   assign rsp_value  = rval_ff;
   assign rsp_status = rst_ff;

endmodule

[verif/infix_expression_evaluator_core_test.sv]
`timescale 1ns / 1ps
// testbench for infix_expression_evaluator_core: streams expression characters, checks value and status
// depends on iee_pkg and the core rtl; holds its own behavioural evaluator for expected results
module infix_expression_evaluator_core_test;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_char_code;
   logic        req_is_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_value;
   logic [2:0]  rsp_status;

   infix_expression_evaluator_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_char_code(req_char_code), .req_is_last(req_is_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_value(rsp_value), .rsp_status(rsp_status)
   );

   // clock, period 4 ns
   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   // evaluator state
   iee_pkg::op_type     ops_held [iee_pkg::StackDepth];
   logic [31:0]         vals_held [iee_pkg::StackDepth];
   int                  n_ops, n_vals;
   logic [31:0]         accum;
   logic                in_num;
   iee_pkg::class_type  last_class;
   iee_pkg::status_type err;

   logic [31:0]         want_value [$];
   iee_pkg::status_type want_status [$];
   int                  mismatches;
   int                  send_idle_pct, stall_pct;

   function automatic int rank(iee_pkg::op_type op);
      case (op)
         iee_pkg::OP_ADD, iee_pkg::OP_SUB: return 1;
         iee_pkg::OP_MUL, iee_pkg::OP_DIV: return 2;
         iee_pkg::OP_NEG:                  return 3;
         default:                          return 0;
      endcase
   endfunction

   function automatic void clear_eval();
      n_ops = 0; n_vals = 0; accum = '0; in_num = 1'b0;
      last_class = iee_pkg::PC_START; err = iee_pkg::ST_OK;
   endfunction

   function automatic void flag(iee_pkg::status_type s);
      if (err == iee_pkg::ST_OK) err = s;
   endfunction

   function automatic void push_val(logic [31:0] v);
      if (n_vals >= iee_pkg::StackDepth) flag(iee_pkg::ST_OVERFLOW);
      else begin
         vals_held[n_vals] = v; n_vals++;
      end
   endfunction

   function automatic void push_op(iee_pkg::op_type op);
      if (n_ops >= iee_pkg::StackDepth) flag(iee_pkg::ST_OVERFLOW);
      else begin
         ops_held[n_ops] = op; n_ops++;
      end
   endfunction

   // signed divide truncating toward zero, wrapping
   function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma, mb, q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   function automatic void do_op(iee_pkg::op_type op);
      logic [31:0] a, b, r;
      if (op == iee_pkg::OP_NEG) begin
         if (n_vals < 1) flag(iee_pkg::ST_MALFORMED);
         else vals_held[n_vals-1] = -vals_held[n_vals-1];
         return;
      end
      if (n_vals < 2) begin
         flag(iee_pkg::ST_MALFORMED);
         return;
      end
      b = vals_held[n_vals-1];
      a = vals_held[n_vals-2];
      case (op)
         iee_pkg::OP_ADD: r = a + b;
         iee_pkg::OP_SUB: r = a - b;
         iee_pkg::OP_MUL: r = a * b;
         default: begin
            if (b == 0) begin
               flag(iee_pkg::ST_DIVZERO);
               return;
            end
            r = sdiv(a, b);
         end
      endcase
      n_vals--;
      vals_held[n_vals-1] = r;
   endfunction

   function automatic void close_number();
      if (in_num) begin
         push_val(accum); in_num = 1'b0; accum = '0;
      end
   endfunction

   function automatic void take_char(logic [7:0] c);
      iee_pkg::op_type op, top;
      if (c == " ") return;
      if (c >= "0" && c <= "9") begin
         accum = accum * 10 + (c - "0");
         in_num = 1'b1; last_class = iee_pkg::PC_OTHER;
         return;
      end
      close_number();
      if (err != iee_pkg::ST_OK) return;
      if (c == "(") begin
         push_op(iee_pkg::OP_OPEN); last_class = iee_pkg::PC_OPEN;
      end else if (c == ")") begin
         forever begin
            if (err != iee_pkg::ST_OK) break;
            if (n_ops == 0) begin
               flag(iee_pkg::ST_PARENS); break;
            end
            n_ops--; top = ops_held[n_ops];
            if (top == iee_pkg::OP_OPEN) break;
            do_op(top);
         end
         last_class = iee_pkg::PC_OTHER;
      end else if (c == "~" || (c == "-" && last_class != iee_pkg::PC_OTHER)) begin
         push_op(iee_pkg::OP_NEG); last_class = iee_pkg::PC_OPER;
      end else if (c == "+" || c == "-" || c == "*" || c == "/") begin
         op = (c == "+") ? iee_pkg::OP_ADD : (c == "-") ? iee_pkg::OP_SUB :
              (c == "*") ? iee_pkg::OP_MUL : iee_pkg::OP_DIV;
         while (err == iee_pkg::ST_OK && n_ops > 0) begin
            top = ops_held[n_ops-1];
            if (top == iee_pkg::OP_OPEN || rank(top) < rank(op)) break;
            n_ops--; do_op(top);
         end
         if (err == iee_pkg::ST_OK) push_op(op);
         last_class = iee_pkg::PC_OPER;
      end else begin
         last_class = iee_pkg::PC_OTHER;
      end
   endfunction

   // advance evaluator by one beat, queue a result on the last one
   function automatic void predict_char(logic [7:0] c, logic last);
      iee_pkg::op_type top;
      if (err == iee_pkg::ST_OK) take_char(c);
      if (!last) return;
      if (err == iee_pkg::ST_OK) close_number();
      while (err == iee_pkg::ST_OK && n_ops > 0) begin
         n_ops--; top = ops_held[n_ops];
         if (top == iee_pkg::OP_OPEN) begin
            flag(iee_pkg::ST_PARENS); break;
         end
         do_op(top);
      end
      if (err == iee_pkg::ST_OK && n_vals != 1) flag(iee_pkg::ST_MALFORMED);
      want_value.push_back(err == iee_pkg::ST_OK ? vals_held[0] : 32'd0);
      want_status.push_back(err);
      clear_eval();
   endfunction

   // send one beat, holding it until accepted
   task automatic send_char(logic [7:0] c, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1; req_char_code <= c; req_is_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_char(c, last);
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   // receiver stall
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (want_value.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result value=%h status=%0d",
                                           rsp_value, rsp_status);
         end else begin
            if (rsp_value !== want_value[0] || rsp_status !== want_status[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                           want_value[0], want_status[0], rsp_value, rsp_status);
            end
            void'(want_value.pop_front());
            void'(want_status.pop_front());
         end
      end
   end

   task automatic test_directed();
      send_text("1+2*3");
      send_text("(1+2)*3");
      send_text("10-4-3");
      send_text("100/7/2");
      send_text("-7/2");
      send_text("--5");
      send_text("~3*-(2+1)");
      send_text("1 2 + - 3");
      send_text("2147483647+1");
      send_text("-2147483648/-1");
      send_text("99999999999");
      send_text("5/0");
      send_text("(1+2");
      send_text("1+2)");
      send_text("1+");
      send_text("1 x 2");
      send_text("3x-1");
      send_char(" ", 1'b1);
      send_text("((((((((((((((((1))))))))))))))))");
      send_text("1+(1+(1+(1+(1+(1+(1+(1+(1+(1+(1+(1+(1+(1+(1+(1+1)))))))))))))))");
      send_char(8'hff, 1'b0);
      send_char(8'h80, 1'b0);
      send_char(8'h00, 1'b1);
   endtask

   // random well-formed expression text with random numbers
   function automatic string rand_expr(int depth);
      string s;
      int    k;
      k = $urandom_range(3);
      if (depth > 3 || k == 0) begin
         case ($urandom_range(3))
            0: s = $sformatf("%0d", $urandom_range(9));
            1: s = $sformatf("%0d", $urandom_range(999));
            2: s = $sformatf("%0d", $urandom);
            default: s = $sformatf("%0d", $urandom_range(20));
         endcase
      end else if (k == 1) s = {"(", rand_expr(depth + 1), ")"};
      else if (k == 2) begin
         if ($urandom_range(1)) s = {"-", rand_expr(depth + 1)};
         else s = {"~", rand_expr(depth + 1)};
      end else begin
         case ($urandom_range(3))
            0: s = {rand_expr(depth + 1), "+", rand_expr(depth + 1)};
            1: s = {rand_expr(depth + 1), "-", rand_expr(depth + 1)};
            2: s = {rand_expr(depth + 1), "*", rand_expr(depth + 1)};
            default: s = {rand_expr(depth + 1), "/", rand_expr(depth + 1)};
         endcase
      end
      if ($urandom_range(9) == 0) s = {s, " "};
      return s;
   endfunction

   task automatic test_random(int n_chars);
      string s;
      string pool;
      int    sent, i, len;
      pool = "0123456789+-*/~() ";
      sent = 0;
      while (sent < n_chars) begin
         if ($urandom_range(9) < 8) begin
            s = rand_expr(0);
            // occasional corruption of one character
            if ($urandom_range(7) == 0) begin
               i = $urandom_range(s.len() - 1);
               s[i] = pool[$urandom_range(pool.len() - 1)];
            end
            send_text(s);
            sent += s.len();
         end else begin
            len = $urandom_range(8);
            for (i = 0; i <= len; i++)
               send_char(($urandom_range(3) == 0) ? 8'($urandom)
                         : pool[$urandom_range(pool.len() - 1)], i == len);
            sent += len + 1;
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (want_value.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      mismatches = 0;
      send_idle_pct = 0; stall_pct = 0;
      clear_eval();
      reset = 1'b1; req_valid = 1'b0; req_char_code = '0; req_is_last = 1'b0;
      rsp_stall = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(400);
      send_idle_pct = 65; stall_pct = 0;
      test_random(450);
      send_idle_pct = 0; stall_pct = 65;
      test_random(450);
      send_idle_pct = 14; stall_pct = 14;
      test_random(450);
      drain();
      if (mismatches == 0 && want_value.size() == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   // run limit
   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
